>>> rtl/eor_pkg.sv
// ----------------------------------------------------------------------------
// eor_pkg
// Shared types and constants for the ellipse outline rasterizer.
// ----------------------------------------------------------------------------
package eor_pkg;

   localparam int MAX_DIM     = 1024;
   localparam int COORD_W     = 16;
   localparam int DIM_W       = 11;
   localparam int OFF_W       = 10;
   localparam int SQ_W        = 18;
   localparam int ERR_W       = 32;
   localparam int COLOR_W     = 32;
   localparam int OP_W        = 8;
   localparam int MUL_B_W     = 12;
   localparam int MUL_P_W     = SQ_W + 1 + MUL_B_W;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_STEP  = 1'b1
   } cmd_type;

   // decoded request as held in the queue between front and back
   typedef struct packed {
      cmd_type              cmd;
      logic [COORD_W-1:0]   left_x;
      logic [COORD_W-1:0]   top_y;
      logic [OFF_W-1:0]     axis_a;
      logic [OFF_W-1:0]     axis_b;
      logic [COLOR_W-1:0]   color;
      logic [OP_W-1:0]      op;
   } req_entry_type;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_SQ_A  = 8'b0000_0010,
      ST_SQ_B  = 8'b0000_0100,
      ST_SQ_C  = 8'b0000_1000,
      ST_INIT  = 8'b0001_0000,
      ST_MUL_X = 8'b0010_0000,
      ST_MUL_Y = 8'b0100_0000,
      ST_STEP  = 8'b1000_0000
   } state_type;

endpackage

>>> rtl/ellipse_outline_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// ellipse_outline_rasterizer_unit
// Midpoint ellipse outline generator with queue-style request and result ports.
// ----------------------------------------------------------------------------
// A start request (command 0) loads a new box and produces no result; each step
// request (command 1) advances one point and yields the four mirrored points,
// marked last when the y offset reaches zero; a step with no walk is dropped.
// Requests enter a two-entry queue, so up to two can be pushed while the engine
// is busy. The engine works one request at a time through a single shared
// 18x12 multiplier: a step runs fetch, two multiplier passes and update; a
// start runs fetch, three multiplier passes and init. Results sit in one
// output register; a step whose result cannot be written holds the engine in
// its update cycle until that register is popped.
module ellipse_outline_rasterizer_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic                              req_command,
   input  logic signed [eor_pkg::COORD_W-1:0] req_left_x,
   input  logic signed [eor_pkg::COORD_W-1:0] req_top_y,
   input  logic [eor_pkg::DIM_W-1:0]         req_width,
   input  logic [eor_pkg::DIM_W-1:0]         req_height,
   input  logic [eor_pkg::COLOR_W-1:0]       req_color,
   input  logic [eor_pkg::OP_W-1:0]          req_raster_op,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic signed [eor_pkg::COORD_W-1:0] rsp_east_x,
   output logic signed [eor_pkg::COORD_W-1:0] rsp_west_x,
   output logic signed [eor_pkg::COORD_W-1:0] rsp_south_y,
   output logic signed [eor_pkg::COORD_W-1:0] rsp_north_y,
   output logic [eor_pkg::COLOR_W-1:0]       rsp_pixel_color,
   output logic [eor_pkg::OP_W-1:0]          rsp_pixel_op,
   output logic                              rsp_last_point
);

   logic                   q_valid;
   logic                   q_take;
   eor_pkg::req_entry_type q_entry;

   eor_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_command   (req_command),
      .req_left_x    (req_left_x),
      .req_top_y     (req_top_y),
      .req_width     (req_width),
      .req_height    (req_height),
      .req_color     (req_color),
      .req_raster_op (req_raster_op),
      .q_valid       (q_valid),
      .q_entry       (q_entry),
      .q_take        (q_take)
   );

   eor_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_entry         (q_entry),
      .q_take          (q_take),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_east_x      (rsp_east_x),
      .rsp_west_x      (rsp_west_x),
      .rsp_south_y     (rsp_south_y),
      .rsp_north_y     (rsp_north_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_pixel_op    (rsp_pixel_op),
      .rsp_last_point  (rsp_last_point)
   );

endmodule

>>> rtl/eor_front.sv
// ----------------------------------------------------------------------------
// eor_front
// Request intake: decodes the box into semi-axes and queues the request.
// ----------------------------------------------------------------------------
module eor_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic                              req_command,
   input  logic signed [eor_pkg::COORD_W-1:0] req_left_x,
   input  logic signed [eor_pkg::COORD_W-1:0] req_top_y,
   input  logic [eor_pkg::DIM_W-1:0]         req_width,
   input  logic [eor_pkg::DIM_W-1:0]         req_height,
   input  logic [eor_pkg::COLOR_W-1:0]       req_color,
   input  logic [eor_pkg::OP_W-1:0]          req_raster_op,
   output logic                              q_valid,
   output eor_pkg::req_entry_type            q_entry,
   input  logic                              q_take
);

   function automatic logic [eor_pkg::OFF_W-1:0] semi_axis(
      input logic [eor_pkg::DIM_W-1:0] dim
   );
      logic [eor_pkg::DIM_W-1:0] d;
      logic [eor_pkg::DIM_W-1:0] dm1;
      begin
         d = dim;
         if (d == '0) begin
            d = eor_pkg::DIM_W'(1);
         end
         if (d > eor_pkg::DIM_W'(eor_pkg::MAX_DIM)) begin
            d = eor_pkg::DIM_W'(eor_pkg::MAX_DIM);
         end
         dm1 = d - eor_pkg::DIM_W'(1);
         semi_axis = dm1[eor_pkg::OFF_W:1];
      end
   endfunction

   eor_pkg::req_entry_type              mem_ff [eor_pkg::QUEUE_DEPTH];
   eor_pkg::req_entry_type              wr_entry;
   logic [eor_pkg::QPTR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [eor_pkg::QPTR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [eor_pkg::QCNT_W-1:0]          count_ff, count_in;
   logic                                push_ok;
   logic                                pop_ok;

   assign req_full = (count_ff == eor_pkg::QCNT_W'(eor_pkg::QUEUE_DEPTH));
   assign q_valid  = (count_ff != '0);
   assign q_entry  = mem_ff[rd_ptr_ff];
   assign push_ok  = req_push && !req_full;
   assign pop_ok   = q_take && q_valid;

   always_comb begin
      wr_entry.cmd    = eor_pkg::cmd_type'(req_command);
      wr_entry.left_x = req_left_x;
      wr_entry.top_y  = req_top_y;
      wr_entry.axis_a = semi_axis(req_width);
      wr_entry.axis_b = semi_axis(req_height);
      wr_entry.color  = req_color;
      wr_entry.op     = req_raster_op;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = wr_ptr_ff + eor_pkg::QPTR_W'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = rd_ptr_ff + eor_pkg::QPTR_W'(1);
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + eor_pkg::QCNT_W'(1);
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - eor_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/eor_back.sv
// ----------------------------------------------------------------------------
// eor_back
// Ellipse walk engine: shared multiplier, error terms and result register.
// ----------------------------------------------------------------------------
module eor_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  eor_pkg::req_entry_type            q_entry,
   output logic                              q_take,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic signed [eor_pkg::COORD_W-1:0] rsp_east_x,
   output logic signed [eor_pkg::COORD_W-1:0] rsp_west_x,
   output logic signed [eor_pkg::COORD_W-1:0] rsp_south_y,
   output logic signed [eor_pkg::COORD_W-1:0] rsp_north_y,
   output logic [eor_pkg::COLOR_W-1:0]       rsp_pixel_color,
   output logic [eor_pkg::OP_W-1:0]          rsp_pixel_op,
   output logic                              rsp_last_point
);

   eor_pkg::state_type                 state_ff, state_in;
   eor_pkg::req_entry_type             cmd_ff, cmd_in;
   logic                               running_ff, running_in;
   logic [eor_pkg::COORD_W-1:0]        center_x_ff, center_x_in;
   logic [eor_pkg::COORD_W-1:0]        center_y_ff, center_y_in;
   logic [eor_pkg::SQ_W-1:0]           w2_ff, w2_in;
   logic [eor_pkg::SQ_W-1:0]           h2_ff, h2_in;
   logic [eor_pkg::OFF_W-1:0]          off_x_ff, off_x_in;
   logic [eor_pkg::OFF_W-1:0]          off_y_ff, off_y_in;
   logic [eor_pkg::ERR_W-1:0]          err_s_ff, err_s_in;
   logic [eor_pkg::ERR_W-1:0]          err_t_ff, err_t_in;
   logic [eor_pkg::COLOR_W-1:0]        color_ff, color_in;
   logic [eor_pkg::OP_W-1:0]           op_ff, op_in;
   logic [eor_pkg::ERR_W-1:0]          prod_ff, prod_in;
   logic [eor_pkg::ERR_W-1:0]          px_ff, px_in;
   logic                               out_valid_ff, out_valid_in;
   logic [eor_pkg::COORD_W-1:0]        east_ff, east_in;
   logic [eor_pkg::COORD_W-1:0]        west_ff, west_in;
   logic [eor_pkg::COORD_W-1:0]        south_ff, south_in;
   logic [eor_pkg::COORD_W-1:0]        north_ff, north_in;
   logic [eor_pkg::COLOR_W-1:0]        ocolor_ff, ocolor_in;
   logic [eor_pkg::OP_W-1:0]           oop_ff, oop_in;
   logic                               olast_ff, olast_in;

   logic [eor_pkg::SQ_W-1:0]           mul_a;
   logic signed [eor_pkg::MUL_B_W-1:0] mul_b;
   logic signed [eor_pkg::MUL_P_W-1:0] mul_p;
   logic                               out_free;
   logic [eor_pkg::ERR_W-1:0]          xs, xt, ys, yt;
   logic [eor_pkg::OFF_W-1:0]          nx, ny;
   logic [eor_pkg::COORD_W-1:0]        nx_ext, ny_ext;

   // 18-bit unsigned by 12-bit signed, shared by all multiply phases
   assign mul_p    = $signed({1'b0, mul_a}) * mul_b;
   assign out_free = !out_valid_ff || rsp_pop;

   assign xs = {px_ff[eor_pkg::ERR_W-2:0], 1'b0};
   assign xt = xs - eor_pkg::ERR_W'({h2_ff, 1'b0});
   assign ys = {prod_ff[eor_pkg::ERR_W-2:0], 1'b0};
   assign yt = ys - eor_pkg::ERR_W'({w2_ff, 1'b0});

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      running_in   = running_ff;
      center_x_in  = center_x_ff;
      center_y_in  = center_y_ff;
      w2_in        = w2_ff;
      h2_in        = h2_ff;
      off_x_in     = off_x_ff;
      off_y_in     = off_y_ff;
      err_s_in     = err_s_ff;
      err_t_in     = err_t_ff;
      color_in     = color_ff;
      op_in        = op_ff;
      px_in        = px_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      east_in      = east_ff;
      west_in      = west_ff;
      south_in     = south_ff;
      north_in     = north_ff;
      ocolor_in    = ocolor_ff;
      oop_in       = oop_ff;
      olast_in     = olast_ff;
      q_take       = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      nx           = off_x_ff;
      ny           = off_y_ff;

      case (state_ff)
         eor_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_take = 1'b1;
               cmd_in = q_entry;
               if (q_entry.cmd == eor_pkg::CMD_START) begin
                  state_in = eor_pkg::ST_SQ_A;
               end else if (running_ff) begin
                  state_in = eor_pkg::ST_MUL_X;
               end
            end
         end
         eor_pkg::ST_SQ_A: begin
            mul_a    = eor_pkg::SQ_W'(cmd_ff.axis_a);
            mul_b    = {2'b00, cmd_ff.axis_a};
            state_in = eor_pkg::ST_SQ_B;
         end
         eor_pkg::ST_SQ_B: begin
            w2_in    = prod_ff[eor_pkg::SQ_W-1:0];
            mul_a    = eor_pkg::SQ_W'(cmd_ff.axis_b);
            mul_b    = {2'b00, cmd_ff.axis_b};
            state_in = eor_pkg::ST_SQ_C;
         end
         eor_pkg::ST_SQ_C: begin
            // a^2 * (2b - 1)
            h2_in    = prod_ff[eor_pkg::SQ_W-1:0];
            mul_a    = w2_ff;
            mul_b    = $signed({1'b0, cmd_ff.axis_b, 1'b0}) - eor_pkg::MUL_B_W'(1);
            state_in = eor_pkg::ST_INIT;
         end
         eor_pkg::ST_INIT: begin
            err_s_in    = eor_pkg::ERR_W'({h2_ff, 1'b0}) - prod_ff;
            err_t_in    = eor_pkg::ERR_W'(h2_ff) - {prod_ff[eor_pkg::ERR_W-2:0], 1'b0};
            center_x_in = cmd_ff.left_x + eor_pkg::COORD_W'(cmd_ff.axis_a);
            center_y_in = cmd_ff.top_y + eor_pkg::COORD_W'(cmd_ff.axis_b);
            off_x_in    = '0;
            off_y_in    = cmd_ff.axis_b;
            color_in    = cmd_ff.color;
            op_in       = cmd_ff.op;
            running_in  = 1'b1;
            state_in    = eor_pkg::ST_IDLE;
         end
         eor_pkg::ST_MUL_X: begin
            // h^2 * (2x + 3)
            mul_a    = h2_ff;
            mul_b    = $signed({off_x_ff[eor_pkg::OFF_W-1], off_x_ff, 1'b0})
                       + eor_pkg::MUL_B_W'(3);
            state_in = eor_pkg::ST_MUL_Y;
         end
         eor_pkg::ST_MUL_Y: begin
            // w^2 * (2y - 2)
            px_in    = prod_ff;
            mul_a    = w2_ff;
            mul_b    = $signed({off_y_ff[eor_pkg::OFF_W-1], off_y_ff, 1'b0})
                       - eor_pkg::MUL_B_W'(2);
            state_in = eor_pkg::ST_STEP;
         end
         eor_pkg::ST_STEP: begin
            if (err_s_ff[eor_pkg::ERR_W-1]) begin
               err_s_in = err_s_ff + xs;
               err_t_in = err_t_ff + xt;
               nx       = off_x_ff + eor_pkg::OFF_W'(1);
            end else if (err_t_ff[eor_pkg::ERR_W-1]) begin
               err_s_in = err_s_ff + xs - ys;
               err_t_in = err_t_ff + xt - yt;
               nx       = off_x_ff + eor_pkg::OFF_W'(1);
               ny       = off_y_ff - eor_pkg::OFF_W'(1);
            end else begin
               err_s_in = err_s_ff - ys;
               err_t_in = err_t_ff - yt;
               ny       = off_y_ff - eor_pkg::OFF_W'(1);
            end
            if (out_free) begin
               off_x_in     = nx;
               off_y_in     = ny;
               out_valid_in = 1'b1;
               east_in      = center_x_ff + nx_ext;
               west_in      = center_x_ff - nx_ext;
               south_in     = center_y_ff + ny_ext;
               north_in     = center_y_ff - ny_ext;
               ocolor_in    = color_ff;
               oop_in       = op_ff;
               olast_in     = (ny == '0) || ny[eor_pkg::OFF_W-1];
               if ((ny == '0) || ny[eor_pkg::OFF_W-1]) begin
                  running_in = 1'b0;
               end
               state_in = eor_pkg::ST_IDLE;
            end else begin
               err_s_in = err_s_ff;
               err_t_in = err_t_ff;
            end
         end
         default: begin
            state_in = eor_pkg::ST_IDLE;
         end
      endcase
   end

   assign nx_ext  = {{(eor_pkg::COORD_W-eor_pkg::OFF_W){nx[eor_pkg::OFF_W-1]}}, nx};
   assign ny_ext  = {{(eor_pkg::COORD_W-eor_pkg::OFF_W){ny[eor_pkg::OFF_W-1]}}, ny};
   // y product held while a step waits for the result register
   assign prod_in = (state_ff == eor_pkg::ST_STEP) ? prod_ff
                    : {{(eor_pkg::ERR_W-eor_pkg::MUL_P_W){mul_p[eor_pkg::MUL_P_W-1]}}, mul_p};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= eor_pkg::ST_IDLE;
         running_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      center_x_ff <= center_x_in;
      center_y_ff <= center_y_in;
      w2_ff       <= w2_in;
      h2_ff       <= h2_in;
      off_x_ff    <= off_x_in;
      off_y_ff    <= off_y_in;
      err_s_ff    <= err_s_in;
      err_t_ff    <= err_t_in;
      color_ff    <= color_in;
      op_ff       <= op_in;
      prod_ff     <= prod_in;
      px_ff       <= px_in;
      east_ff     <= east_in;
      west_ff     <= west_in;
      south_ff    <= south_in;
      north_ff    <= north_in;
      ocolor_ff   <= ocolor_in;
      oop_ff      <= oop_in;
      olast_ff    <= olast_in;
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_east_x      = east_ff;
   assign rsp_west_x      = west_ff;
   assign rsp_south_y     = south_ff;
   assign rsp_north_y     = north_ff;
   assign rsp_pixel_color = ocolor_ff;
   assign rsp_pixel_op    = oop_ff;
   assign rsp_last_point  = olast_ff;

endmodule

>>> dv/ellipse_outline_rasterizer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ellipse_outline_rasterizer_unit_tb
// Self-checking bench for the midpoint ellipse outline rasterizer.
// ----------------------------------------------------------------------------
// Start and step requests come from a pending queue and go to a clocked
// driver. Each accepted request runs through a local midpoint walk that
// queues the expected mirrored points. A clocked monitor pops results and
// compares them field by field. Both sides idle in rotating phases. One long
// receiver hold-off backs the block up until it stalls its input.
// ----------------------------------------------------------------------------
module ellipse_outline_rasterizer_unit_tb;

   typedef struct {
      eor_pkg::cmd_type            cmd;
      logic [eor_pkg::COORD_W-1:0] left_x;
      logic [eor_pkg::COORD_W-1:0] top_y;
      logic [eor_pkg::DIM_W-1:0]   width;
      logic [eor_pkg::DIM_W-1:0]   height;
      logic [eor_pkg::COLOR_W-1:0] color;
      logic [eor_pkg::OP_W-1:0]    op;
   } ellipse_req_type;

   typedef struct {
      logic [eor_pkg::COORD_W-1:0] east_x;
      logic [eor_pkg::COORD_W-1:0] west_x;
      logic [eor_pkg::COORD_W-1:0] south_y;
      logic [eor_pkg::COORD_W-1:0] north_y;
      logic [eor_pkg::COLOR_W-1:0] color;
      logic [eor_pkg::OP_W-1:0]    op;
      logic                        last;
   } outline_point_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_push = 1'b0;
   logic                               req_full;
   logic                               req_command = 1'b0;
   logic signed [eor_pkg::COORD_W-1:0] req_left_x = '0;
   logic signed [eor_pkg::COORD_W-1:0] req_top_y = '0;
   logic [eor_pkg::DIM_W-1:0]          req_width = '0;
   logic [eor_pkg::DIM_W-1:0]          req_height = '0;
   logic [eor_pkg::COLOR_W-1:0]        req_color = '0;
   logic [eor_pkg::OP_W-1:0]           req_raster_op = '0;
   logic                               rsp_empty;
   logic                               rsp_pop = 1'b0;
   logic signed [eor_pkg::COORD_W-1:0] rsp_east_x;
   logic signed [eor_pkg::COORD_W-1:0] rsp_west_x;
   logic signed [eor_pkg::COORD_W-1:0] rsp_south_y;
   logic signed [eor_pkg::COORD_W-1:0] rsp_north_y;
   logic [eor_pkg::COLOR_W-1:0]        rsp_pixel_color;
   logic [eor_pkg::OP_W-1:0]           rsp_pixel_op;
   logic                               rsp_last_point;

   ellipse_req_type   request_queue[$];
   outline_point_type point_queue[$];
   int                sent_count = 0;
   int                fault_count = 0;
   int                hold_left = 0;
   bit                hold_done = 1'b0;

   // walk state
   logic [eor_pkg::COORD_W-1:0] cen_x, cen_y;
   logic [eor_pkg::SQ_W-1:0]    sq_w, sq_h;
   logic [eor_pkg::OFF_W-1:0]   walk_x, walk_y;
   logic [eor_pkg::ERR_W-1:0]   err_s, err_t;
   logic                        walking;
   logic [eor_pkg::COLOR_W-1:0] keep_color;
   logic [eor_pkg::OP_W-1:0]    keep_op;

   ellipse_outline_rasterizer_unit DUT (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_command     (req_command),
      .req_left_x      (req_left_x),
      .req_top_y       (req_top_y),
      .req_width       (req_width),
      .req_height      (req_height),
      .req_color       (req_color),
      .req_raster_op   (req_raster_op),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_east_x      (rsp_east_x),
      .rsp_west_x      (rsp_west_x),
      .rsp_south_y     (rsp_south_y),
      .rsp_north_y     (rsp_north_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_pixel_op    (rsp_pixel_op),
      .rsp_last_point  (rsp_last_point)
   );

   function automatic logic [eor_pkg::OFF_W-1:0] semi_axis_of(
      input logic [eor_pkg::DIM_W-1:0] dim
   );
      logic [eor_pkg::DIM_W-1:0] d;
      d = dim;
      if (d == '0) d = eor_pkg::DIM_W'(1);
      if (d > eor_pkg::DIM_W'(eor_pkg::MAX_DIM)) d = eor_pkg::DIM_W'(eor_pkg::MAX_DIM);
      d = d - eor_pkg::DIM_W'(1);
      return d[eor_pkg::OFF_W:1];
   endfunction

   function automatic logic [eor_pkg::ERR_W-1:0] widen_offset(
      input logic [eor_pkg::OFF_W-1:0] v
   );
      return {{(eor_pkg::ERR_W-eor_pkg::OFF_W){v[eor_pkg::OFF_W-1]}}, v};
   endfunction

   function automatic logic [eor_pkg::COORD_W-1:0] rand_coord();
      return eor_pkg::COORD_W'($urandom);
   endfunction

   function automatic logic [eor_pkg::COLOR_W-1:0] rand_color();
      return eor_pkg::COLOR_W'($urandom);
   endfunction

   function automatic logic [eor_pkg::OP_W-1:0] rand_op();
      return eor_pkg::OP_W'($urandom);
   endfunction

   task automatic trace_ellipse(input ellipse_req_type rq);
      logic [31:0]       a, b, a2, b2, x, y, w2, h2, xs, xt, ys, yt;
      outline_point_type pt;
      if (rq.cmd == eor_pkg::CMD_START) begin
         a = 32'(semi_axis_of(rq.width));
         b = 32'(semi_axis_of(rq.height));
         a2 = a * a;
         b2 = b * b;
         err_s = a2 * (32'd1 - (b << 1)) + (b2 << 1);
         err_t = b2 - ((a2 * ((b << 1) - 32'd1)) << 1);
         sq_w = a2[eor_pkg::SQ_W-1:0];
         sq_h = b2[eor_pkg::SQ_W-1:0];
         cen_x = rq.left_x + a[eor_pkg::COORD_W-1:0];
         cen_y = rq.top_y + b[eor_pkg::COORD_W-1:0];
         walk_x = '0;
         walk_y = b[eor_pkg::OFF_W-1:0];
         keep_color = rq.color;
         keep_op = rq.op;
         walking = 1'b1;
      end else if (walking) begin
         x = widen_offset(walk_x);
         y = widen_offset(walk_y);
         w2 = 32'(sq_w);
         h2 = 32'(sq_h);
         xs = (h2 * ((x << 1) + 32'd3)) << 1;
         xt = (h2 * (x + 32'd1)) << 2;
         ys = (w2 * (y - 32'd1)) << 2;
         yt = (w2 * ((y << 1) - 32'd3)) << 1;
         if (err_s[31]) begin
            err_s = err_s + xs;
            err_t = err_t + xt;
            x = x + 32'd1;
         end else if (err_t[31]) begin
            err_s = err_s + xs - ys;
            err_t = err_t + xt - yt;
            x = x + 32'd1;
            y = y - 32'd1;
         end else begin
            err_s = err_s - ys;
            err_t = err_t - yt;
            y = y - 32'd1;
         end
         walk_x = x[eor_pkg::OFF_W-1:0];
         walk_y = y[eor_pkg::OFF_W-1:0];
         x = widen_offset(walk_x);
         y = widen_offset(walk_y);
         pt.last = (y == 32'd0) || y[31];
         if (pt.last) walking = 1'b0;
         pt.east_x = cen_x + x[eor_pkg::COORD_W-1:0];
         pt.west_x = cen_x - x[eor_pkg::COORD_W-1:0];
         pt.south_y = cen_y + y[eor_pkg::COORD_W-1:0];
         pt.north_y = cen_y - y[eor_pkg::COORD_W-1:0];
         pt.color = keep_color;
         pt.op = keep_op;
         point_queue.push_back(pt);
      end
   endtask

   task automatic add_start(input logic [eor_pkg::COORD_W-1:0] lx,
                            input logic [eor_pkg::COORD_W-1:0] ty,
                            input logic [eor_pkg::DIM_W-1:0] w,
                            input logic [eor_pkg::DIM_W-1:0] h,
                            input logic [eor_pkg::COLOR_W-1:0] col,
                            input logic [eor_pkg::OP_W-1:0] rop);
      ellipse_req_type rq;
      rq.cmd = eor_pkg::CMD_START;
      rq.left_x = lx;
      rq.top_y = ty;
      rq.width = w;
      rq.height = h;
      rq.color = col;
      rq.op = rop;
      request_queue.push_back(rq);
   endtask

   task automatic add_steps(input int n);
      ellipse_req_type rq;
      for (int i = 0; i < n; i++) begin
         rq.cmd = eor_pkg::CMD_STEP;
         rq.left_x = rand_coord();
         rq.top_y = rand_coord();
         rq.width = eor_pkg::DIM_W'($urandom);
         rq.height = eor_pkg::DIM_W'($urandom);
         rq.color = rand_color();
         rq.op = rand_op();
         request_queue.push_back(rq);
      end
   endtask

   // phases: none, sender idle, receiver stall, both light
   function automatic int send_idle_pct();
      case ((sent_count / 90) % 4)
         1: return 69;
         3: return 11;
         default: return 0;
      endcase
   endfunction

   function automatic int recv_stall_pct();
      case ((sent_count / 90) % 4)
         2: return 69;
         3: return 11;
         default: return 0;
      endcase
   endfunction

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("Verification failed");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            trace_ellipse(request_queue.pop_front());
            sent_count <= sent_count + 1;
         end
         if (!req_push || !req_full) begin
            if (request_queue.size() != 0 &&
                (hold_left != 0 || $urandom_range(0, 99) >= send_idle_pct())) begin
               req_push <= 1'b1;
               req_command <= request_queue[0].cmd;
               req_left_x <= request_queue[0].left_x;
               req_top_y <= request_queue[0].top_y;
               req_width <= request_queue[0].width;
               req_height <= request_queue[0].height;
               req_color <= request_queue[0].color;
               req_raster_op <= request_queue[0].op;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, once
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (!hold_done && sent_count >= 200) begin
         hold_left <= 400;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      outline_point_type pt;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (point_queue.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("unexpected point: e=%0d w=%0d s=%0d n=%0d",
                           rsp_east_x, rsp_west_x, rsp_south_y, rsp_north_y);
            end else begin
               pt = point_queue.pop_front();
               if (rsp_east_x !== pt.east_x || rsp_west_x !== pt.west_x ||
                   rsp_south_y !== pt.south_y || rsp_north_y !== pt.north_y ||
                   rsp_pixel_color !== pt.color || rsp_pixel_op !== pt.op ||
                   rsp_last_point !== pt.last) begin
                  fault_count++;
                  if (fault_count <= 10) begin
                     $display("mismatch exp: e=%0d w=%0d s=%0d n=%0d c=%h op=%h last=%b",
                              $signed(pt.east_x), $signed(pt.west_x), $signed(pt.south_y),
                              $signed(pt.north_y), pt.color, pt.op, pt.last);
                     $display("         act: e=%0d w=%0d s=%0d n=%0d c=%h op=%h last=%b",
                              rsp_east_x, rsp_west_x, rsp_south_y, rsp_north_y,
                              rsp_pixel_color, rsp_pixel_op, rsp_last_point);
                  end
               end
            end
         end
         rsp_pop <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct());
      end
   end

   initial begin
      int                        pick;
      bit                        wide_done;
      logic [eor_pkg::DIM_W-1:0] w, h;

      // directed
      add_steps(1);
      add_start(16'h7FFF, 16'h8000, 11'd0, 11'd0, 32'hFFFF_FFFF, 8'hFF);
      add_steps(2);
      add_start(16'h8000, 16'h7FFF, 11'd2047, 11'd2, 32'h0, 8'h0);
      add_steps(1);
      add_start(rand_coord(), rand_coord(), 11'd5, 11'd5, rand_color(), rand_op());
      add_steps(6);
      add_start(16'h0, 16'h0, 11'd1024, 11'd1024, rand_color(), rand_op());
      add_steps(3);
      add_start(rand_coord(), rand_coord(), 11'd3, 11'd7, rand_color(), rand_op());
      add_steps(6);

      // random
      wide_done = 1'b0;
      while (request_queue.size() < 1350) begin
         pick = $urandom_range(0, 99);
         if (!wide_done && request_queue.size() > 500) begin
            add_start(rand_coord(), rand_coord(), 11'd1024, 11'd3, rand_color(), rand_op());
            add_steps(semi_axis_of(11'd1024) + semi_axis_of(11'd3) + 2);
            wide_done = 1'b1;
         end else if (pick < 8) begin
            add_steps($urandom_range(1, 3));
         end else if (pick < 22) begin
            add_start(rand_coord(), rand_coord(),
                      eor_pkg::DIM_W'($urandom_range(0, 2047)),
                      eor_pkg::DIM_W'($urandom_range(0, 2047)),
                      rand_color(), rand_op());
            add_steps($urandom_range(0, 20));
         end else begin
            w = ($urandom_range(0, 99) < 75) ? eor_pkg::DIM_W'($urandom_range(1, 40))
                                             : eor_pkg::DIM_W'($urandom_range(41, 120));
            h = ($urandom_range(0, 99) < 75) ? eor_pkg::DIM_W'($urandom_range(1, 40))
                                             : eor_pkg::DIM_W'($urandom_range(41, 120));
            add_start(rand_coord(), rand_coord(), w, h, rand_color(), rand_op());
            add_steps(semi_axis_of(w) + semi_axis_of(h) + 2);
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (request_queue.size() != 0 || req_push) @(posedge clock);
      while (point_queue.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      if (fault_count == 0 && point_queue.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
